FILE: hw/rtl/jtq_pkg.sv
package jtq_pkg;

  // Field widths.
  localparam int SampleW = 10;
  localparam int PosW    = 8;
  localparam int DzW     = 7;
  localparam int PhaseW  = 2;
  localparam int NumW    = SampleW + PosW;
  localparam int DivCntW = $clog2(PosW);
  localparam int Lanes   = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int InFieldsW  = 2 * SampleW;
  localparam int InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = 2 * PhaseW + 1 + 2 * PosW;
  localparam int OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // Register port.
  localparam int AddrW = 5;
  localparam int DataW = 32;

  localparam logic [2:0] REG_X_IN_MIN = 3'd0;
  localparam logic [2:0] REG_X_IN_MAX = 3'd1;
  localparam logic [2:0] REG_Y_IN_MIN = 3'd2;
  localparam logic [2:0] REG_Y_IN_MAX = 3'd3;
  localparam logic [2:0] REG_OUT_MIN  = 3'd4;
  localparam logic [2:0] REG_OUT_MAX  = 3'd5;
  localparam logic [2:0] REG_CENTER   = 3'd6;
  localparam logic [2:0] REG_DEAD     = 3'd7;

  // Register reset values.
  localparam logic [SampleW-1:0] XInMinRst = SampleW'(36);
  localparam logic [SampleW-1:0] XInMaxRst = SampleW'(213);
  localparam logic [SampleW-1:0] YInMinRst = SampleW'(31);
  localparam logic [SampleW-1:0] YInMaxRst = SampleW'(208);
  localparam logic [PosW-1:0]    OutMinRst = PosW'(37);
  localparam logic [PosW-1:0]    OutMaxRst = PosW'(218);
  localparam logic [PosW-1:0]    CenterRst = PosW'(127);
  localparam logic [DzW-1:0]     DeadRst   = DzW'(19);

  // Gray phase codes in counting order.
  localparam logic [PhaseW-1:0] PH_0 = 2'b00;
  localparam logic [PhaseW-1:0] PH_1 = 2'b01;
  localparam logic [PhaseW-1:0] PH_2 = 2'b11;
  localparam logic [PhaseW-1:0] PH_3 = 2'b10;

  typedef struct packed {
    logic [SampleW-1:0] x_in_min;
    logic [SampleW-1:0] x_in_max;
    logic [SampleW-1:0] y_in_min;
    logic [SampleW-1:0] y_in_max;
    logic [PosW-1:0]    out_min;
    logic [PosW-1:0]    out_max;
    logic [PosW-1:0]    center;
    logic [DzW-1:0]     snap_radius;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic commit;
    logic is_tick;
  } dp_cmd_t;

  function automatic logic [PhaseW-1:0] gray_up(input logic [PhaseW-1:0] g);
    logic [PhaseW-1:0] r;
    case (g)
      PH_0:    r = PH_1;
      PH_1:    r = PH_2;
      PH_2:    r = PH_3;
      default: r = PH_0;
    endcase
    return r;
  endfunction

  function automatic logic [PhaseW-1:0] gray_down(input logic [PhaseW-1:0] g);
    logic [PhaseW-1:0] r;
    case (g)
      PH_0:    r = PH_3;
      PH_3:    r = PH_2;
      PH_2:    r = PH_1;
      default: r = PH_0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/jtq_regs.sv
module jtq_regs import jtq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_X_IN_MIN: cfg_d.x_in_min    = pwdata[SampleW-1:0];
        REG_X_IN_MAX: cfg_d.x_in_max    = pwdata[SampleW-1:0];
        REG_Y_IN_MIN: cfg_d.y_in_min    = pwdata[SampleW-1:0];
        REG_Y_IN_MAX: cfg_d.y_in_max    = pwdata[SampleW-1:0];
        REG_OUT_MIN:  cfg_d.out_min     = pwdata[PosW-1:0];
        REG_OUT_MAX:  cfg_d.out_max     = pwdata[PosW-1:0];
        REG_CENTER:   cfg_d.center      = pwdata[PosW-1:0];
        REG_DEAD:     cfg_d.snap_radius = pwdata[DzW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  // Register read decode.
  always_comb begin
    unique case (idx)
      REG_X_IN_MIN: prdata = DataW'(cfg_q.x_in_min);
      REG_X_IN_MAX: prdata = DataW'(cfg_q.x_in_max);
      REG_Y_IN_MIN: prdata = DataW'(cfg_q.y_in_min);
      REG_Y_IN_MAX: prdata = DataW'(cfg_q.y_in_max);
      REG_OUT_MIN:  prdata = DataW'(cfg_q.out_min);
      REG_OUT_MAX:  prdata = DataW'(cfg_q.out_max);
      REG_CENTER:   prdata = DataW'(cfg_q.center);
      REG_DEAD:     prdata = DataW'(cfg_q.snap_radius);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_in_min    <= XInMinRst;
      cfg_q.x_in_max    <= XInMaxRst;
      cfg_q.y_in_min    <= YInMinRst;
      cfg_q.y_in_max    <= YInMaxRst;
      cfg_q.out_min     <= OutMinRst;
      cfg_q.out_max     <= OutMaxRst;
      cfg_q.center      <= CenterRst;
      cfg_q.snap_radius <= DeadRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/jtq_ctrl.sv
module jtq_ctrl import jtq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_tick_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               tick_q, tick_d;
  logic               out_valid_q, out_valid_d;
  logic               in_ready;
  logic               load, mul, div_step, commit;

  // Sequencer: multiply, one quotient bit per cycle, then commit; a tick goes straight to commit.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    tick_d   = tick_q;
    in_ready = 1'b0;
    load     = 1'b0;
    mul      = 1'b0;
    div_step = 1'b0;
    commit   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          tick_d = in_tick_i;
          if (in_tick_i) begin
            state_d = ST_DONE;
          end else begin
            load    = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        mul     = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(PosW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // The state registers double as the output register, so wait for it.
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load     = load;
  assign cmd_o.mul      = mul;
  assign cmd_o.div_step = div_step;
  assign cmd_o.commit   = commit;
  assign cmd_o.is_tick  = tick_q;

endmodule

FILE: hw/rtl/jtq_dp.sv
module jtq_dp import jtq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  dp_cmd_t            cmd_i,
  input  logic [SampleW-1:0] x_sample_i,
  input  logic [SampleW-1:0] y_sample_i,
  output logic [PhaseW-1:0]  x_phase_o,
  output logic [PhaseW-1:0]  y_phase_o,
  output logic               pending_o,
  output logic [PosW-1:0]    x_target_o,
  output logic [PosW-1:0]    y_target_o
);

  // Per-axis work registers (payload, no reset).
  logic [SampleW-1:0] diff_q [Lanes];
  logic [SampleW-1:0] den_q  [Lanes];
  logic               byp_q  [Lanes];
  logic [SampleW-1:0] rem_q  [Lanes];
  logic [PosW-1:0]    quo_q  [Lanes];

  // Per-axis architectural state.
  logic [PosW-1:0]   tgt_q  [Lanes];
  logic [PosW-1:0]   pos_q  [Lanes];
  logic [PhaseW-1:0] gray_q [Lanes];
  logic              primed_q;

  logic [SampleW-1:0] smp    [Lanes];
  logic [SampleW-1:0] lo     [Lanes];
  logic [SampleW-1:0] hi     [Lanes];
  logic [SampleW-1:0] clamp  [Lanes];
  logic [NumW-1:0]    prod   [Lanes];
  logic [SampleW:0]   trial  [Lanes];
  logic [SampleW:0]   sub    [Lanes];
  logic               ge     [Lanes];
  logic [PosW-1:0]    mraw   [Lanes];
  logic [PosW:0]      m_plus [Lanes];
  logic               snap   [Lanes];
  logic [PosW-1:0]    mapped [Lanes];
  logic [PosW-1:0]    span;
  logic [PosW:0]      hi_edge;
  logic               out_inv;

  assign smp[0] = x_sample_i;
  assign smp[1] = y_sample_i;
  assign lo[0]  = cfg_i.x_in_min;
  assign lo[1]  = cfg_i.y_in_min;
  assign hi[0]  = cfg_i.x_in_max;
  assign hi[1]  = cfg_i.y_in_max;

  assign span    = cfg_i.out_max - cfg_i.out_min;
  assign out_inv = cfg_i.out_max < cfg_i.out_min;
  assign hi_edge = {1'b0, cfg_i.center} + {2'b00, cfg_i.snap_radius};

  // Clamp, scale, one restoring division step and the dead zone, per axis.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (smp[l] < lo[l]) begin
        clamp[l] = lo[l];
      end else if (smp[l] > hi[l]) begin
        clamp[l] = hi[l];
      end else begin
        clamp[l] = smp[l];
      end
      prod[l]  = NumW'(diff_q[l]) * NumW'(span);
      trial[l] = {rem_q[l], quo_q[l][PosW-1]};
      sub[l]   = trial[l] - {1'b0, den_q[l]};
      ge[l]    = trial[l] >= {1'b0, den_q[l]};
      mraw[l]  = byp_q[l] ? cfg_i.out_min : quo_q[l] + cfg_i.out_min;
      // Strictly inside center +/- snap_radius, without going negative.
      m_plus[l] = {1'b0, mraw[l]} + {2'b00, cfg_i.snap_radius};
      snap[l]   = ({1'b0, mraw[l]} < hi_edge) && (m_plus[l] > {1'b0, cfg_i.center});
      mapped[l] = snap[l] ? cfg_i.center : mraw[l];
    end
  end

  // Division work registers.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      if (cmd_i.load) begin
        diff_q[l] <= clamp[l] - lo[l];
        den_q[l]  <= hi[l] - lo[l];
        byp_q[l]  <= (hi[l] <= lo[l]) || out_inv;
      end else if (cmd_i.mul) begin
        rem_q[l] <= prod[l][NumW-1:PosW];
        quo_q[l] <= prod[l][PosW-1:0];
      end else if (cmd_i.div_step) begin
        rem_q[l] <= ge[l] ? sub[l][SampleW-1:0] : trial[l][SampleW-1:0];
        quo_q[l] <= {quo_q[l][PosW-2:0], ge[l]};
      end
    end
  end

  // Targets, positions and phases change only when a result is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Lanes; l++) begin
        tgt_q[l]  <= '0;
        pos_q[l]  <= '0;
        gray_q[l] <= PH_0;
      end
      primed_q <= 1'b0;
    end else if (cmd_i.commit) begin
      if (cmd_i.is_tick) begin
        for (int l = 0; l < Lanes; l++) begin
          if (pos_q[l] < tgt_q[l]) begin
            pos_q[l]  <= pos_q[l] + 1'b1;
            gray_q[l] <= gray_up(gray_q[l]);
          end else if (pos_q[l] > tgt_q[l]) begin
            pos_q[l]  <= pos_q[l] - 1'b1;
            gray_q[l] <= gray_down(gray_q[l]);
          end
        end
      end else begin
        for (int l = 0; l < Lanes; l++) begin
          tgt_q[l] <= mapped[l];
          if (!primed_q) begin
            pos_q[l] <= mapped[l];
          end
        end
        primed_q <= 1'b1;
      end
    end
  end

  assign x_phase_o  = gray_q[0];
  assign y_phase_o  = gray_q[1];
  assign x_target_o = tgt_q[0];
  assign y_target_o = tgt_q[1];
  assign pending_o  = (pos_q[0] != tgt_q[0]) || (pos_q[1] != tgt_q[1]);

endmodule

FILE: hw/rtl/joystick_to_quadrature.sv
// Joystick to quadrature converter. A sample transaction (tuser 0) clamps the
// x and y readings to their input windows, scales them onto out_min..out_max,
// snaps values strictly inside center +/- snap_radius to center, and sets them
// as the new axis targets; the first sample after reset also sets the positions.
// A tick transaction (tuser 1) moves each axis one step toward its target and
// steps its Gray phase up or down to match. Every transaction returns one
// result with the state after it. One item is handled at a time: a sample
// goes through acceptance, the multiply, the bit-serial restoring division
// of both axes side by side, and the commit; a tick goes from acceptance
// straight to the commit, and the result is registered at the commit. The
// result stays on the output until taken; the next item is accepted
// meanwhile, but its result waits for the output to be free.
module joystick_to_quadrature import jtq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // x_sample, y_sample, zero pad
  input  logic                 s_axis_tuser,  // func
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // x_phase, y_phase, pending,
                                              // x_target_out, y_target_out, zero pad
  // Register port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  cfg_t              cfg;
  dp_cmd_t           cmd;
  logic [PhaseW-1:0] x_phase, y_phase;
  logic              pending;
  logic [PosW-1:0]   x_target, y_target;

  jtq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_tick_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  jtq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .x_sample_i (s_axis_tdata[SampleW-1:0]),
    .y_sample_i (s_axis_tdata[2*SampleW-1:SampleW]),
    .x_phase_o  (x_phase),
    .y_phase_o  (y_phase),
    .pending_o  (pending),
    .x_target_o (x_target),
    .y_target_o (y_target)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {{(OutTdataW - OutFieldsW){1'b0}},
                         y_target, x_target, pending, y_phase, x_phase};

endmodule

FILE: hw/rtl/jtq_checker.sv
module jtq_checker import jtq_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // One item in flight: no acceptance right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A waiting result is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  // A waiting result does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Each quadrature output moves at most one Gray step between cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(m_axis_tdata[PhaseW-1:0] ^ $past(m_axis_tdata[PhaseW-1:0])) <= 1 &&
    $countones(m_axis_tdata[2*PhaseW-1:PhaseW] ^
               $past(m_axis_tdata[2*PhaseW-1:PhaseW])) <= 1)
    else $error("quadrature phase skipped a step");

endmodule

bind joystick_to_quadrature jtq_checker u_jtq_checker (.*);

FILE: tb/sv/joystick_to_quadrature_checker.sv
// Watches the register port and both streams of the joystick to quadrature
// converter, keeps its own copy of the block state, and compares every result
// transaction with the oldest prediction.
module joystick_to_quadrature_checker import jtq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // x_sample, y_sample, zero pad
  input  logic                 s_axis_tuser,  // func
  // Output stream.
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,  // x_phase, y_phase, pending,
                                              // x_target_out, y_target_out, zero pad
  // Register port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  input  logic [DataW-1:0]     prdata,
  input  logic                 pready,
  output int                   error_count_o,
  output int                   outstanding_o
);

  typedef struct {
    logic [PhaseW-1:0] x_phase;
    logic [PhaseW-1:0] y_phase;
    logic              pending;
    logic [PosW-1:0]   x_target;
    logic [PosW-1:0]   y_target;
  } pins_t;

  cfg_t              cfg;
  logic [PosW-1:0]   x_goal, y_goal, x_pos, y_pos;
  logic [PhaseW-1:0] x_ph, y_ph;
  logic              primed;
  pins_t             expected_pins_q[$];

  initial begin
    error_count_o = 0;
    outstanding_o = 0;
  end

  // Clamp a reading to its window, scale it onto the output range and snap it
  // to center when it falls strictly inside the dead zone.
  function automatic logic [PosW-1:0] scaled_target(input int raw, input int lo,
                                                    input int hi);
    int v;
    int m;
    int omin;
    int omax;
    int c;
    int dz;
    v    = raw;
    omin = int'(cfg.out_min);
    omax = int'(cfg.out_max);
    c    = int'(cfg.center);
    dz   = int'(cfg.snap_radius);
    if (v < lo) begin
      v = lo;
    end else if (v > hi) begin
      v = hi;
    end
    if (hi <= lo || omax < omin) begin
      m = omin;
    end else begin
      m = ((v - lo) * (omax - omin)) / (hi - lo) + omin;
    end
    if (m < c + dz && m > c - dz) begin
      m = c;
    end
    return m[PosW-1:0];
  endfunction

  // One Gray step in counting order, up or down.
  function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] ph,
                                                   input logic up);
    case (ph)
      PH_0:    return up ? PH_1 : PH_3;
      PH_1:    return up ? PH_2 : PH_0;
      PH_2:    return up ? PH_3 : PH_1;
      default: return up ? PH_0 : PH_2;
    endcase
  endfunction

  task automatic step_toward(inout logic [PosW-1:0] pos, input logic [PosW-1:0] goal,
                             inout logic [PhaseW-1:0] ph);
    if (pos < goal) begin
      pos = pos + 1'b1;
      ph  = next_phase(ph, 1'b1);
    end else if (pos > goal) begin
      pos = pos - 1'b1;
      ph  = next_phase(ph, 1'b0);
    end
  endtask

  // Apply one accepted item to the shadow state and queue the pins it yields.
  task automatic advance_encoder(input logic is_tick, input logic [SampleW-1:0] xs,
                                 input logic [SampleW-1:0] ys);
    pins_t r;
    if (!is_tick) begin
      x_goal = scaled_target(int'(xs), int'(cfg.x_in_min), int'(cfg.x_in_max));
      y_goal = scaled_target(int'(ys), int'(cfg.y_in_min), int'(cfg.y_in_max));
      if (!primed) begin
        x_pos  = x_goal;
        y_pos  = y_goal;
        primed = 1'b1;
      end
    end else begin
      step_toward(x_pos, x_goal, x_ph);
      step_toward(y_pos, y_goal, y_ph);
    end
    r.x_phase  = x_ph;
    r.y_phase  = y_ph;
    r.pending  = (x_pos != x_goal) || (y_pos != y_goal);
    r.x_target = x_goal;
    r.y_target = y_goal;
    expected_pins_q.push_back(r);
  endtask

  function automatic logic [DataW-1:0] register_value(input logic [2:0] idx);
    case (idx)
      REG_X_IN_MIN: return DataW'(cfg.x_in_min);
      REG_X_IN_MAX: return DataW'(cfg.x_in_max);
      REG_Y_IN_MIN: return DataW'(cfg.y_in_min);
      REG_Y_IN_MAX: return DataW'(cfg.y_in_max);
      REG_OUT_MIN:  return DataW'(cfg.out_min);
      REG_OUT_MAX:  return DataW'(cfg.out_max);
      REG_CENTER:   return DataW'(cfg.center);
      default:      return DataW'(cfg.snap_radius);
    endcase
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [DataW-1:0] val);
    case (idx)
      REG_X_IN_MIN: cfg.x_in_min    = val[SampleW-1:0];
      REG_X_IN_MAX: cfg.x_in_max    = val[SampleW-1:0];
      REG_Y_IN_MIN: cfg.y_in_min    = val[SampleW-1:0];
      REG_Y_IN_MAX: cfg.y_in_max    = val[SampleW-1:0];
      REG_OUT_MIN:  cfg.out_min     = val[PosW-1:0];
      REG_OUT_MAX:  cfg.out_max     = val[PosW-1:0];
      REG_CENTER:   cfg.center      = val[PosW-1:0];
      default:      cfg.snap_radius = val[DzW-1:0];
    endcase
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      error_count_o++;
    end
  endtask

  // Monitor all three ports at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pins_t want;
    if (!rst_ni) begin
      cfg.x_in_min    = XInMinRst;
      cfg.x_in_max    = XInMaxRst;
      cfg.y_in_min    = YInMinRst;
      cfg.y_in_max    = YInMaxRst;
      cfg.out_min     = OutMinRst;
      cfg.out_max     = OutMaxRst;
      cfg.center      = CenterRst;
      cfg.snap_radius = DeadRst;
      x_goal = '0;
      y_goal = '0;
      x_pos  = '0;
      y_pos  = '0;
      x_ph   = PH_0;
      y_ph   = PH_0;
      primed = 1'b0;
      expected_pins_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_register(paddr[4:2], pwdata);
        end else begin
          check_field("register read", int'(register_value(paddr[4:2])), int'(prdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_encoder(s_axis_tuser, s_axis_tdata[SampleW-1:0],
                        s_axis_tdata[2*SampleW-1:SampleW]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pins_q.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, m_axis_tdata);
          error_count_o++;
        end else begin
          want = expected_pins_q.pop_front();
          check_field("x_phase", int'(want.x_phase), int'(m_axis_tdata[1:0]));
          check_field("y_phase", int'(want.y_phase), int'(m_axis_tdata[3:2]));
          check_field("pending", int'(want.pending), int'(m_axis_tdata[4]));
          check_field("x_target_out", int'(want.x_target), int'(m_axis_tdata[12:5]));
          check_field("y_target_out", int'(want.y_target), int'(m_axis_tdata[20:13]));
        end
      end
    end
    outstanding_o = expected_pins_q.size();
  end

endmodule

FILE: tb/sv/joystick_to_quadrature_tb.sv
// Stimulus and verdict for the joystick to quadrature converter.
module joystick_to_quadrature_tb;
  import jtq_pkg::*;

  localparam logic FUNC_SAMPLE   = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;
  localparam int   NumPhases     = 10;
  localparam int   ItemsPerPhase = 193;
  localparam int   HoldCycles    = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;   // x_sample, y_sample, zero pad
  logic                 s_axis_tuser = 1'b0; // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // x_phase, y_phase, pending,
                                             // x_target_out, y_target_out, zero pad
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  int   send_idle_pct = 9;
  int   recv_idle_pct = 68;
  logic hold_off = 1'b0;
  logic pressure_go = 1'b0;
  int   error_count;
  int   outstanding;

  always #5 clk_i = ~clk_i;

  joystick_to_quadrature u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  joystick_to_quadrature_checker u_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  // Result side: random stalls, or a full stop while a hold-off is active.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long hold-off so that the block fills up and stalls its input.
  initial begin
    wait (pressure_go);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL joystick_to_quadrature");
    $finish;
  end

  // Offer one item and wait until the transaction completes.
  task automatic send_item(input logic func, input logic [SampleW-1:0] xs,
                           input logic [SampleW-1:0] ys);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= InTdataW'({ys, xs});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] idx,
                            input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Write every register, read all of them back, then release the bus.
  task automatic load_setting(input cfg_t c);
    reg_access(1'b1, REG_X_IN_MIN, DataW'(c.x_in_min));
    reg_access(1'b1, REG_X_IN_MAX, DataW'(c.x_in_max));
    reg_access(1'b1, REG_Y_IN_MIN, DataW'(c.y_in_min));
    reg_access(1'b1, REG_Y_IN_MAX, DataW'(c.y_in_max));
    reg_access(1'b1, REG_OUT_MIN, DataW'(c.out_min));
    reg_access(1'b1, REG_OUT_MAX, DataW'(c.out_max));
    reg_access(1'b1, REG_CENTER, DataW'(c.center));
    reg_access(1'b1, REG_DEAD, DataW'(c.snap_radius));
    for (int i = 0; i < 8; i++) begin
      reg_access(1'b0, 3'(i), '0);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fixed settings cover full ranges, empty and inverted windows, an inverted
  // output range and dead zones reaching past both ends of the byte range.
  function automatic cfg_t stick_setting(input int p);
    cfg_t c;
    c = '{x_in_min: 0, x_in_max: 1023, y_in_min: 0, y_in_max: 1023,
          out_min: 0, out_max: 255, center: 128, snap_radius: 0};
    case (p)
      1: begin
        c.x_in_min    = 512;
        c.x_in_max    = 512;
        c.y_in_min    = 1023;
        c.y_in_max    = 0;
        c.out_min     = 10;
        c.out_max     = 245;
        c.center      = 0;
        c.snap_radius = 127;
      end
      2: begin
        c.x_in_min    = 100;
        c.x_in_max    = 900;
        c.out_min     = 200;
        c.out_max     = 50;
        c.center      = 255;
        c.snap_radius = 127;
      end
      3: begin
        c.x_in_min  = 500;
        c.x_in_max  = 503;
        c.y_in_min  = 1;
        c.y_in_max  = 2;
        c.center    = 255;
      end
      4: begin
        c.x_in_min    = 1023;
        c.x_in_max    = 1023;
        c.y_in_max    = 1;
        c.out_min     = 255;
        c.out_max     = 255;
        c.center      = 255;
        c.snap_radius = 127;
      end
      default: begin
        if (p > 4) begin
          c.x_in_min    = SampleW'($urandom_range(0, 700));
          c.x_in_max    = SampleW'($urandom_range(0, 15) == 0 ? $urandom_range(0, 1023)
                                   : $urandom_range(c.x_in_min, 1023));
          c.y_in_min    = SampleW'($urandom_range(0, 700));
          c.y_in_max    = SampleW'($urandom_range(0, 15) == 0 ? $urandom_range(0, 1023)
                                   : $urandom_range(c.y_in_min, 1023));
          c.out_min     = PosW'($urandom_range(0, 120));
          c.out_max     = PosW'($urandom_range(0, 15) == 0 ? $urandom_range(0, 255)
                                : $urandom_range(c.out_min, 255));
          c.center      = PosW'($urandom_range(0, 255));
          c.snap_radius = DzW'($urandom_range(0, 127));
        end
      end
    endcase
    return c;
  endfunction

  // Readings near the window edges, the field extremes, or anything.
  function automatic logic [SampleW-1:0] pick_reading(input logic [SampleW-1:0] lo,
                                                      input logic [SampleW-1:0] hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return lo;
      3:       return hi;
      4:       return lo - 1'b1;
      5:       return hi + 1'b1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // A sample followed by a run of ticks, mostly short, sometimes long enough
  // to walk a position all the way to its target.
  task automatic stick_traffic(input int count, input cfg_t c);
    int k;
    int run;
    k = 0;
    while (k < count) begin
      send_item(FUNC_SAMPLE, pick_reading(c.x_in_min, c.x_in_max),
                pick_reading(c.y_in_min, c.y_in_max));
      k++;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 130) : $urandom_range(0, 12);
      while (run > 0 && k < count) begin
        send_item(FUNC_TICK, SampleW'($urandom), SampleW'($urandom));
        run--;
        k++;
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset setting: ticks before any sample, the
    // priming sample, full swings, snapping to center and window edges.
    send_item(FUNC_TICK, '1, '1);
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_SAMPLE, '0, '1);
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_SAMPLE, '1, '0);
    repeat (5) send_item(FUNC_TICK, '1, '0);
    send_item(FUNC_SAMPLE, 10'd124, 10'd119);
    send_item(FUNC_SAMPLE, 10'd36, 10'd31);
    send_item(FUNC_SAMPLE, 10'd213, 10'd208);
    send_item(FUNC_SAMPLE, 10'h2AA, 10'h155);
    send_item(FUNC_SAMPLE, 10'h155, 10'h2AA);
    repeat (5) send_item(FUNC_TICK, 10'h2AA, 10'h155);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p < 4) begin
        send_idle_pct = 9;
        recv_idle_pct <= 68;
      end else if (p < 7) begin
        send_idle_pct = 68;
        recv_idle_pct <= 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      c = stick_setting(p);
      load_setting(c);
      if (p == 7) begin
        pressure_go = 1'b1;
      end
      stick_traffic(ItemsPerPhase, c);
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("PASS joystick_to_quadrature");
    end else begin
      $display("FAIL joystick_to_quadrature");
    end
    $finish;
  end

endmodule
